// ===== hdl/fpa_pkg.sv =====
package fpa_pkg;

  typedef enum logic [3:0] {
    ACT_ADD = 4'd0,
    ACT_SUB = 4'd1,
    ACT_MUL = 4'd2,
    ACT_DIV = 4'd3,
    ACT_GT  = 4'd4,
    ACT_GE  = 4'd5,
    ACT_LT  = 4'd6,
    ACT_LE  = 4'd7,
    ACT_EQ  = 4'd8,
    ACT_NE  = 4'd9,
    ACT_MIN = 4'd10,
    ACT_MAX = 4'd11,
    ACT_INC = 4'd12,
    ACT_DEC = 4'd13
  } action_e;

  localparam int unsigned ActionWidth = 4;
  localparam int unsigned FieldWidth  = 32;

endpackage

// ===== hdl/fixed_point_alu.sv =====
// Throughput: one item per cycle while the output is not stalled; the divider has one register stage per quotient bit.
// A stall at the output freezes the whole pipeline, so no item is lost or repeated.
// Reset clears only the valid bits; data registers are not reset.
module fixed_point_alu
  import fpa_pkg::*;
#(
  parameter int unsigned FRAC_BITS  = 8,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ActionWidth-1:0]       action_i,
  input  logic signed [FieldWidth-1:0] operand_a_i,
  input  logic signed [FieldWidth-1:0] operand_b_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [FieldWidth-1:0] result_raw_o,
  output logic                         compare_flag_o,
  output logic                         divide_error_o
);

  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned NW  = W + FRAC_BITS + 2;
  localparam int unsigned DW  = W + 2;
  localparam int unsigned DEP = NW + 1;

  typedef struct packed {
    logic [ActionWidth-1:0] act;
    logic [W-1:0]           simple;
    logic                   flag;
    logic                   err;
    logic                   neg;
  } side_t;

  logic adv;
  assign adv        = !out_stall_i || !out_valid_o;
  assign in_stall_o = !adv;

  // Stage 0: operand capture and the simple operations.
  logic signed [W-1:0] a, b;
  assign a = operand_a_i[W-1:0];
  assign b = operand_b_i[W-1:0];

  side_t s0;
  logic [W-1:0] ma, mb;
  always_comb begin
    s0        = '0;
    s0.act    = action_i;
    s0.neg    = a[W-1] ^ b[W-1];
    ma        = a[W-1] ? W'(-a) : W'(a);
    mb        = b[W-1] ? W'(-b) : W'(b);
    unique case (action_i)
      ACT_ADD: s0.simple = W'(a + b);
      ACT_SUB: s0.simple = W'(a - b);
      ACT_GT:  s0.flag = a > b;
      ACT_GE:  s0.flag = a >= b;
      ACT_LT:  s0.flag = a < b;
      ACT_LE:  s0.flag = a <= b;
      ACT_EQ:  s0.flag = a == b;
      ACT_NE:  s0.flag = a != b;
      ACT_MIN: s0.simple = (a <= b) ? a : b;
      ACT_MAX: s0.simple = (a >= b) ? a : b;
      ACT_INC: s0.simple = W'(a + 1);
      ACT_DEC: s0.simple = W'(a - 1);
      ACT_DIV: s0.err = (b == '0);
      default: ;
    endcase
  end

  side_t          side_q [DEP];
  logic [DEP-1:0] vld_q;
  logic [W-1:0]   ma_q, mb_q;
  logic [2*W-1:0] prod_q;
  logic [2*W-1:0] prod_r_q [NW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[DEP-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= s0;
      for (int i = 1; i < DEP; i++) side_q[i] <= side_q[i-1];
      ma_q   <= ma;
      mb_q   <= mb;
      prod_q <= ma_q * mb_q;
      prod_r_q[0] <= prod_q + (2*W)'(1 << (FRAC_BITS - 1));
      for (int i = 1; i < NW - 1; i++) prod_r_q[i] <= prod_r_q[i-1];
    end
  end

  // Divider: numerator 2|a|<<F + |b|, denominator 2|b|.
  logic [NW-1:0] num;
  logic [DW-1:0] den;
  logic [NW-1:0] quo;
  assign num = (NW'(ma_q) << (FRAC_BITS + 1)) + NW'(mb_q);
  assign den = DW'(mb_q) << 1;

  fpa_div #(.NW(NW), .DW(DW)) u_div (
    .clk_i (clk_i),
    .adv_i (adv),
    .num_i (num),
    .den_i (den),
    .quo_o (quo)
  );

  // Final select; divider output aligns with side_q[NW] after NW+1 registers.
  side_t        sf;
  logic [W-1:0] mulm, res_d;
  logic [W-1:0] res_q;
  logic         flag_q, err_q;
  assign sf   = side_q[NW];
  assign mulm = W'(prod_r_q[NW-2] >> FRAC_BITS);
  always_comb begin
    unique case (sf.act)
      ACT_MUL: res_d = sf.neg ? W'(-mulm) : mulm;
      ACT_DIV: res_d = sf.err ? '0 : (sf.neg ? W'(-quo[W-1:0]) : quo[W-1:0]);
      default: res_d = sf.simple;
    endcase
  end

  logic out_v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= vld_q[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q  <= res_d;
      flag_q <= sf.flag;
      err_q  <= sf.err;
    end
  end

  assign out_valid_o    = out_v_q;
  assign result_raw_o   = FieldWidth'($signed(res_q));
  assign compare_flag_o = flag_q;
  assign divide_error_o = err_q;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_raw_o))
    else $error("stalled result changed");
  a_flag_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(compare_flag_o && divide_error_o))
    else $error("flag and error both set");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_error_o |-> result_raw_o == '0)
    else $error("divide error with nonzero result");

endmodule

// ===== hdl/fpa_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, all stages advance on adv_i.
module fpa_div
  import fpa_pkg::*;
#(
  parameter int unsigned NW = 48,
  parameter int unsigned DW = 33
) (
  input  logic          clk_i,
  input  logic          adv_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] quo_o
);

  logic [NW-1:0] num_q [NW+1];
  logic [DW-1:0] den_q [NW+1];
  logic [DW:0]   rem_q [NW+1];

  assign num_q[0] = num_i;
  assign den_q[0] = den_i;
  assign rem_q[0] = '0;

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW+1:0] shifted;
    logic [DW+1:0] diff;
    logic [DW:0]   rem_d;
    logic [NW-1:0] num_d;
    logic          take;
    always_comb begin
      shifted = {rem_q[s], num_q[s][NW-1]};
      diff    = shifted - {2'b00, den_q[s]};
      take    = !diff[DW+1];
      rem_d   = take ? diff[DW:0] : shifted[DW:0];
      num_d   = {num_q[s][NW-2:0], take};
    end
    logic [NW-1:0] n_r;
    logic [DW-1:0] d_r;
    logic [DW:0]   r_r;
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        n_r <= num_d;
        d_r <= den_q[s];
        r_r <= rem_d;
      end
    end
    assign num_q[s+1] = n_r;
    assign den_q[s+1] = d_r;
    assign rem_q[s+1] = r_r;
  end

  assign quo_o = num_q[NW];

endmodule

// ===== sim/fixed_point_alu_tb.sv =====
module fixed_point_alu_tb;
  import fpa_pkg::*;

  localparam int unsigned FracBits   = 8;
  localparam int unsigned DataWidth  = 32;
  localparam int unsigned Latency    = DataWidth + FracBits + 3;
  localparam int unsigned RandItems  = 1950;
  localparam longint     CycleLimit = 1000000;

  typedef struct packed {
    logic signed [FieldWidth-1:0] raw;
    logic                         flag;
    logic                         err;
  } alu_result_t;

  typedef struct {
    logic [ActionWidth-1:0]       act;
    logic signed [FieldWidth-1:0] a;
    logic signed [FieldWidth-1:0] b;
    bit                           typed;
    alu_result_t                  res;
  } stim_row_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic [ActionWidth-1:0]       action_i;
  logic signed [FieldWidth-1:0] operand_a_i;
  logic signed [FieldWidth-1:0] operand_b_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic signed [FieldWidth-1:0] result_raw_o;
  logic                         compare_flag_o;
  logic                         divide_error_o;

  alu_result_t pending_results[$];
  int          error_count;
  int          sent_count;
  int          recv_count;
  int          div_err_count;
  bit          stim_done;
  longint      cycle_count;
  stim_row_t   directed_rows[$];

  fixed_point_alu #(
    .FRAC_BITS (FracBits),
    .DATA_WIDTH(DataWidth)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .operand_a_i   (operand_a_i),
    .operand_b_i   (operand_b_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_raw_o  (result_raw_o),
    .compare_flag_o(compare_flag_o),
    .divide_error_o(divide_error_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Magnitudes and products are carried in 128 bits so nothing overflows.
  function automatic alu_result_t predict_alu(logic [ActionWidth-1:0] act,
                                              logic signed [FieldWidth-1:0] a,
                                              logic signed [FieldWidth-1:0] b);
    alu_result_t r;
    logic [127:0] ma, mb, q;
    bit           neg;
    r   = '0;
    ma  = a < 0 ? 128'(-longint'(a)) : 128'(a);
    mb  = b < 0 ? 128'(-longint'(b)) : 128'(b);
    neg = (a < 0) != (b < 0);
    case (act)
      ACT_ADD: r.raw = a + b;
      ACT_SUB: r.raw = a - b;
      ACT_MUL: begin
        q = (ma * mb + (128'd1 << (FracBits - 1))) >> FracBits;
        r.raw = neg ? -q[FieldWidth-1:0] : q[FieldWidth-1:0];
      end
      ACT_DIV: begin
        if (b == 0) begin
          r.err = 1'b1;
        end else begin
          q = (2 * (ma << FracBits) + mb) / (2 * mb);
          r.raw = neg ? -q[FieldWidth-1:0] : q[FieldWidth-1:0];
        end
      end
      ACT_GT:  r.flag = a > b;
      ACT_GE:  r.flag = a >= b;
      ACT_LT:  r.flag = a < b;
      ACT_LE:  r.flag = a <= b;
      ACT_EQ:  r.flag = a == b;
      ACT_NE:  r.flag = a != b;
      ACT_MIN: r.raw = a <= b ? a : b;
      ACT_MAX: r.raw = a >= b ? a : b;
      ACT_INC: r.raw = a + 1;
      ACT_DEC: r.raw = a - 1;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [FieldWidth-1:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $urandom_range(0, 1) ? -$signed($urandom_range(0, 4096))
                                     : $signed($urandom_range(0, 4096));
      3: return $signed($urandom) >>> $urandom_range(0, 31);
      default: return $signed($urandom);
    endcase
  endfunction

  task automatic send_item(logic [ActionWidth-1:0] act,
                           logic signed [FieldWidth-1:0] a,
                           logic signed [FieldWidth-1:0] b);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if ($urandom_range(0, 1) == 0) gap = 0;
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(predict_alu(act, a, b));
    sent_count++;
  endtask

  function automatic void add_row(logic [ActionWidth-1:0] act, int a, int b,
                                  bit typed, alu_result_t res);
    stim_row_t row;
    row.act   = act;
    row.a     = a;
    row.b     = b;
    row.typed = typed;
    row.res   = res;
    directed_rows.push_back(row);
  endfunction

  initial begin
    alu_result_t zero_res;
    zero_res = '0;
    add_row(ACT_ADD, 32'sh7fff_ffff, 1, 1'b1, '{32'sh8000_0000, 1'b0, 1'b0});
    add_row(ACT_SUB, 32'sh8000_0000, 1, 1'b1, '{32'sh7fff_ffff, 1'b0, 1'b0});
    add_row(ACT_MUL, 32'sh0000_0180, 32'sh0000_0100, 1'b1, '{32'sh180, 1'b0, 1'b0});
    add_row(ACT_MUL, -1, 128, 1'b0, zero_res);
    add_row(ACT_MUL, 32'sh8000_0000, 32'sh8000_0000, 1'b0, zero_res);
    add_row(ACT_DIV, 32'sh0000_0100, 0, 1'b1, '{32'sh0, 1'b0, 1'b1});
    add_row(ACT_DIV, 32'sh8000_0000, 0, 1'b1, '{32'sh0, 1'b0, 1'b1});
    add_row(ACT_DIV, 1, 512, 1'b0, zero_res);
    add_row(ACT_DIV, -1, 512, 1'b0, zero_res);
    add_row(ACT_DIV, 32'sh8000_0000, -1, 1'b0, zero_res);
    add_row(ACT_DIV, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0, zero_res);
    add_row(ACT_GT, 32'sh7fff_ffff, 32'sh8000_0000, 1'b1, '{32'sh0, 1'b1, 1'b0});
    add_row(ACT_GE, 5, 5, 1'b1, '{32'sh0, 1'b1, 1'b0});
    add_row(ACT_LT, 32'sh8000_0000, 32'sh7fff_ffff, 1'b1, '{32'sh0, 1'b1, 1'b0});
    add_row(ACT_LE, 6, 5, 1'b1, '{32'sh0, 1'b0, 1'b0});
    add_row(ACT_EQ, -1, -1, 1'b1, '{32'sh0, 1'b1, 1'b0});
    add_row(ACT_NE, -1, -1, 1'b1, '{32'sh0, 1'b0, 1'b0});
    add_row(ACT_MIN, 32'sh8000_0000, 32'sh7fff_ffff, 1'b1,
            '{32'sh8000_0000, 1'b0, 1'b0});
    add_row(ACT_MAX, 32'sh8000_0000, 32'sh7fff_ffff, 1'b1,
            '{32'sh7fff_ffff, 1'b0, 1'b0});
    add_row(ACT_INC, 32'sh7fff_ffff, 32'sh1234_5678, 1'b1,
            '{32'sh8000_0000, 1'b0, 1'b0});
    add_row(ACT_DEC, 32'sh8000_0000, -1, 1'b1, '{32'sh7fff_ffff, 1'b0, 1'b0});
    add_row(4'd14, 7, 9, 1'b1, zero_res);
    add_row(4'd15, -1, -1, 1'b1, zero_res);

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    action_i    = '0;
    operand_a_i = '0;
    operand_b_i = '0;
    stim_done   = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].act, directed_rows[i].a, directed_rows[i].b);
      // Hand-typed values guard against a predictor that shares the block's mistake.
      if (directed_rows[i].typed &&
          pending_results[$] !== directed_rows[i].res) begin
        $display("%0t: typed row %0d disagrees: expected %h, actual %h", $time, i,
                 directed_rows[i].res, pending_results[$]);
        error_count++;
      end
    end

    for (int n = 0; n < RandItems; n++) begin
      logic [ActionWidth-1:0] act;
      act = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(14, 15))
                                         : 4'($urandom_range(0, 13));
      if (act == ACT_DIV && $urandom_range(0, 7) == 0) begin
        send_item(act, rand_operand(), 0);
      end else begin
        send_item(act, rand_operand(), rand_operand());
      end
    end
    in_valid_i <= 1'b0;
    stim_done  <= 1'b1;
  end

  // Receiver: draws a stall length per item, sometimes none at all.
  initial begin
    int wait_cycles;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      wait_cycles = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 18);
      repeat (wait_cycles) begin
        out_stall_i <= 1'b1;
        @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    alu_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      recv_count++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h/%b/%b", $time,
                 result_raw_o, compare_flag_o, divide_error_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (want.err) div_err_count++;
        if (result_raw_o !== want.raw || compare_flag_o !== want.flag ||
            divide_error_o !== want.err) begin
          $display("%0t: mismatch: expected %h/%b/%b, actual %h/%b/%b", $time,
                   want.raw, want.flag, want.err,
                   result_raw_o, compare_flag_o, divide_error_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (!(stim_done && pending_results.size() == 0) && cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               pending_results.size());
      $display("** fixed_point_alu: FAILED **");
      $finish;
    end else begin
      repeat (Latency + 20) @(posedge clk_i);
      $display("Sent %0d items across all actions, received %0d results,", sent_count,
               recv_count);
      $display("%0d of them divide-by-zero, with random gaps and stalls.", div_err_count);
      if (error_count == 0) begin
        $display("** fixed_point_alu: PASSED **");
      end else begin
        $display("** fixed_point_alu: FAILED **");
      end
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
hdl/fpa_pkg.sv
hdl/fpa_div.sv
hdl/fixed_point_alu.sv
sim/fixed_point_alu_tb.sv
